@@ sv/vrms_pkg.sv @@
package vrms_pkg;

  // Fixed field widths of the stream words.
  localparam int COORD_W  = 8;
  localparam int SIZE_W   = 9;
  localparam int SAMPLE_W = 16;
  localparam int ISO_W    = 16;
  localparam int COUNT_W  = 16;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 2;
  localparam int KIND_W   = 3;

  // Widths of the voxel index arithmetic, sized for size registers up to 511.
  localparam int YX_W    = COORD_W + SIZE_W;        // y * size_x
  localparam int PLANE_W = 2 * SIZE_W;              // size_x * size_y
  localparam int ZP_W    = COORD_W + PLANE_W;       // z * plane
  localparam int XY_W    = YX_W + 1;                // x + y * size_x
  localparam int SUM_W   = ZP_W + 1;                // full linear index

  // Operation codes carried in the input tuser.
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSIDE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FREEZE = 2'd3;

  // Status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_W-1:0] REG_SIZE_X    = 2'd0;
  localparam logic [REG_W-1:0] REG_SIZE_Y    = 2'd1;
  localparam logic [REG_W-1:0] REG_SIZE_Z    = 2'd2;
  localparam logic [REG_W-1:0] REG_ISO_LEVEL = 2'd3;

  // What the back end has to do with a classified word.
  typedef enum logic [KIND_W-1:0] {
    JOB_ADD,
    JOB_READ,
    JOB_RANGE,
    JOB_REJECT,
    JOB_FREEZE
  } job_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_FETCH,
    B_MUL,
    B_DIV,
    B_WRITE,
    B_DONE
  } back_state_t;

endpackage

@@ sv/vrms_queue.sv @@
module vrms_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  // Two-entry queue between the front and back ends.
  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ sv/vrms_front.sv @@
module vrms_front #(
  parameter int MAX_VOXELS = 65536,
  parameter int VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 hold,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [vrms_pkg::MODE_W-1:0]          in_mode,
  input  logic [vrms_pkg::COORD_W-1:0]         in_x,
  input  logic [vrms_pkg::COORD_W-1:0]         in_y,
  input  logic [vrms_pkg::COORD_W-1:0]         in_z,
  input  logic [vrms_pkg::SAMPLE_W-1:0]        in_sample,
  input  logic [vrms_pkg::SIZE_W-1:0]          size_x,
  input  logic [vrms_pkg::SIZE_W-1:0]          size_y,
  input  logic [vrms_pkg::SIZE_W-1:0]          size_z,
  output logic                                 job_valid,
  input  logic                                 job_ready,
  output vrms_pkg::job_kind_t                  job_kind,
  output logic [$clog2(MAX_VOXELS)-1:0]        job_idx,
  output logic [VALUE_BITS-1:0]                job_sample
);

  localparam int IDX_W = $clog2(MAX_VOXELS);

  vrms_pkg::front_state_t state;
  vrms_pkg::front_state_t state_next;

  logic [vrms_pkg::MODE_W-1:0]  mode_r;
  logic [vrms_pkg::COORD_W-1:0] x_r;
  logic [vrms_pkg::COORD_W-1:0] y_r;
  logic [vrms_pkg::COORD_W-1:0] z_r;
  logic [VALUE_BITS-1:0]        sample_r;
  logic [vrms_pkg::YX_W-1:0]    yx;
  logic [vrms_pkg::PLANE_W-1:0] plane;
  logic [vrms_pkg::ZP_W-1:0]    zp;
  logic [vrms_pkg::XY_W-1:0]    xy;
  logic                         coord_bad;
  logic                         frozen;
  logic [vrms_pkg::SUM_W-1:0]   lin_idx;
  logic                         idx_bad;

  always_comb begin
    state_next = state;
    case (state)
      vrms_pkg::F_IDLE: begin
        if (in_valid && !hold) begin
          state_next = vrms_pkg::F_MUL1;
        end
      end
      vrms_pkg::F_MUL1: state_next = vrms_pkg::F_MUL2;
      vrms_pkg::F_MUL2: state_next = vrms_pkg::F_PUSH;
      vrms_pkg::F_PUSH: begin
        if (job_ready) begin
          state_next = vrms_pkg::F_IDLE;
        end
      end
      default: state_next = vrms_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    job_valid = 1'b0;
    case (state)
      vrms_pkg::F_IDLE: in_ready  = !hold;
      vrms_pkg::F_PUSH: job_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        job_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrms_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Index arithmetic: two multiply steps, then one add and compare at push.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r   <= in_mode;
      x_r      <= in_x;
      y_r      <= in_y;
      z_r      <= in_z;
      sample_r <= VALUE_BITS'(in_sample);
    end
    if (state == vrms_pkg::F_MUL1) begin
      yx        <= vrms_pkg::YX_W'(y_r) * vrms_pkg::YX_W'(size_x);
      plane     <= vrms_pkg::PLANE_W'(size_x) * vrms_pkg::PLANE_W'(size_y);
      coord_bad <= ({1'b0, x_r} >= size_x) || ({1'b0, y_r} >= size_y) ||
                   ({1'b0, z_r} >= size_z);
    end
    if (state == vrms_pkg::F_MUL2) begin
      zp <= vrms_pkg::ZP_W'(z_r) * vrms_pkg::ZP_W'(plane);
      xy <= vrms_pkg::XY_W'(x_r) + vrms_pkg::XY_W'(yx);
    end
  end

  assign lin_idx    = vrms_pkg::SUM_W'(zp) + vrms_pkg::SUM_W'(xy);
  assign idx_bad    = (lin_idx >= vrms_pkg::SUM_W'(MAX_VOXELS));
  assign job_idx    = lin_idx[IDX_W-1:0];
  assign job_sample = sample_r;

  // Freeze wins over everything, then a rejected add, then the range check.
  always_comb begin
    if (mode_r == vrms_pkg::MODE_FREEZE) begin
      job_kind = vrms_pkg::JOB_FREEZE;
    end else if ((mode_r == vrms_pkg::MODE_ADD) && frozen) begin
      job_kind = vrms_pkg::JOB_REJECT;
    end else if (coord_bad || idx_bad) begin
      job_kind = vrms_pkg::JOB_RANGE;
    end else if (mode_r == vrms_pkg::MODE_ADD) begin
      job_kind = vrms_pkg::JOB_ADD;
    end else begin
      job_kind = vrms_pkg::JOB_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frozen <= 1'b0;
    end else if (job_valid && job_ready && (job_kind == vrms_pkg::JOB_FREEZE)) begin
      frozen <= 1'b1;
    end
  end

endmodule

@@ sv/vrms_back.sv @@
module vrms_back #(
  parameter int MAX_VOXELS = 65536,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [vrms_pkg::ISO_W-1:0]        iso_level,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  vrms_pkg::job_kind_t               job_kind,
  input  logic [$clog2(MAX_VOXELS)-1:0]     job_idx,
  input  logic [VALUE_BITS-1:0]             job_sample,
  output logic                              clearing,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [vrms_pkg::SAMPLE_W-1:0]     mean_value,
  output logic                              is_inside,
  output logic [vrms_pkg::COUNT_W-1:0]      sample_total,
  output logic [vrms_pkg::STATUS_W-1:0]     status
);

  localparam int IDX_W  = $clog2(MAX_VOXELS);
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int CW     = vrms_pkg::COUNT_W;
  localparam int PROD_W = VALUE_BITS + CW;
  localparam int DATA_W = CW + VALUE_BITS;
  localparam int CMP_W  = (VALUE_BITS > vrms_pkg::ISO_W) ? VALUE_BITS : vrms_pkg::ISO_W;

  vrms_pkg::back_state_t state;
  vrms_pkg::back_state_t state_next;

  logic              occ_mem  [MAX_VOXELS];
  logic [DATA_W-1:0] data_mem [MAX_VOXELS];

  vrms_pkg::job_kind_t   kind_r;
  logic [IDX_W-1:0]      idx_r;
  logic [VALUE_BITS-1:0] sample_r;
  logic [IDX_W-1:0]      clr_addr;
  logic                  occ_rd;
  logic [DATA_W-1:0]     data_rd;
  logic [CW-1:0]         cnt_rd;
  logic [VALUE_BITS-1:0] mean_rd;
  logic [CW-1:0]         n_r;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     sum_full;
  logic [CW-1:0]         rem;
  logic [VALUE_BITS-1:0] dq;
  logic [CNT_W-1:0]      step;
  logic [CW:0]           trial;
  logic [CW:0]           diff;
  logic                  ge;

  logic [VALUE_BITS-1:0]         res_mean;
  logic [CW-1:0]                 res_total;
  logic [vrms_pkg::STATUS_W-1:0] res_status;
  logic                          res_occ;
  logic [CMP_W-1:0]              mean_wide;

  logic [IDX_W-1:0]  mem_addr;
  logic              mem_re;
  logic              occ_we;
  logic              occ_wd;
  logic              data_we;
  logic [DATA_W-1:0] data_wd;
  logic              out_load;
  logic              clr_last;
  logic              div_last;
  logic              add_first;
  logic              add_again;

  assign cnt_rd    = data_rd[DATA_W-1:VALUE_BITS];
  assign mean_rd   = data_rd[VALUE_BITS-1:0];
  assign clr_last  = (clr_addr == IDX_W'(MAX_VOXELS - 1));
  assign div_last  = (step == CNT_W'(VALUE_BITS - 1));
  assign add_first = (kind_r == vrms_pkg::JOB_ADD) && !occ_rd;
  assign add_again = (kind_r == vrms_pkg::JOB_ADD) && occ_rd;

  always_comb begin
    state_next = state;
    case (state)
      vrms_pkg::B_CLEAR: begin
        if (clr_last) begin
          state_next = vrms_pkg::B_IDLE;
        end
      end
      vrms_pkg::B_IDLE: begin
        if (job_valid) begin
          if (job_kind inside {vrms_pkg::JOB_ADD, vrms_pkg::JOB_READ}) begin
            state_next = vrms_pkg::B_FETCH;
          end else begin
            state_next = vrms_pkg::B_DONE;
          end
        end
      end
      vrms_pkg::B_FETCH: begin
        state_next = add_again ? vrms_pkg::B_MUL : vrms_pkg::B_DONE;
      end
      vrms_pkg::B_MUL: state_next = vrms_pkg::B_DIV;
      vrms_pkg::B_DIV: begin
        if (div_last) begin
          state_next = vrms_pkg::B_WRITE;
        end
      end
      vrms_pkg::B_WRITE: state_next = vrms_pkg::B_DONE;
      vrms_pkg::B_DONE: begin
        if (out_load) begin
          state_next = vrms_pkg::B_IDLE;
        end
      end
      default: state_next = vrms_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    clearing  = 1'b0;
    mem_addr  = idx_r;
    mem_re    = 1'b0;
    occ_we    = 1'b0;
    occ_wd    = 1'b1;
    data_we   = 1'b0;
    data_wd   = {n_r, dq};
    out_load  = 1'b0;
    case (state)
      vrms_pkg::B_CLEAR: begin
        clearing = 1'b1;
        mem_addr = clr_addr;
        occ_we   = 1'b1;
        occ_wd   = 1'b0;
      end
      vrms_pkg::B_IDLE: begin
        job_ready = 1'b1;
        mem_addr  = job_idx;
        mem_re    = job_valid;
      end
      vrms_pkg::B_FETCH: begin
        occ_we  = add_first;
        data_we = add_first;
        data_wd = {CW'(1), sample_r};
      end
      vrms_pkg::B_WRITE: data_we = 1'b1;
      vrms_pkg::B_DONE:  out_load = !m_valid || m_ready;
      default: begin
        job_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vrms_pkg::B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == vrms_pkg::B_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  // Voxel store: occupancy bits are swept clear after reset, the data is not.
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[mem_addr] <= occ_wd;
    end
    if (mem_re) begin
      occ_rd <= occ_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[mem_addr] <= data_wd;
    end
    if (mem_re) begin
      data_rd <= data_mem[mem_addr];
    end
  end

  // One quotient bit per step; the quotient is known to fit in VALUE_BITS.
  assign sum_full = prod + PROD_W'(sample_r);
  assign trial    = {rem, dq[VALUE_BITS-1]};
  assign ge       = (trial >= {1'b0, n_r});
  assign diff     = trial - {1'b0, n_r};

  always_ff @(posedge clk) begin
    case (state)
      vrms_pkg::B_IDLE: begin
        if (job_valid) begin
          kind_r    <= job_kind;
          idx_r     <= job_idx;
          sample_r  <= job_sample;
          res_mean  <= '0;
          res_total <= '0;
          res_occ   <= 1'b0;
          if (job_kind == vrms_pkg::JOB_RANGE) begin
            res_status <= vrms_pkg::ST_RANGE;
          end else if (job_kind == vrms_pkg::JOB_REJECT) begin
            res_status <= vrms_pkg::ST_REJECT;
          end else begin
            res_status <= vrms_pkg::ST_OK;
          end
        end
      end
      vrms_pkg::B_FETCH: begin
        if (add_first) begin
          res_mean  <= sample_r;
          res_total <= CW'(1);
          res_occ   <= 1'b1;
        end else if (occ_rd && (kind_r == vrms_pkg::JOB_READ)) begin
          res_mean  <= mean_rd;
          res_total <= cnt_rd;
          res_occ   <= 1'b1;
        end
        // Saturated count: n stays at its maximum and n - 1 is one less.
        if (cnt_rd == {CW{1'b1}}) begin
          n_r  <= cnt_rd;
          prod <= PROD_W'(mean_rd) * PROD_W'(cnt_rd - CW'(1));
        end else begin
          n_r  <= cnt_rd + CW'(1);
          prod <= PROD_W'(mean_rd) * PROD_W'(cnt_rd);
        end
      end
      vrms_pkg::B_MUL: begin
        rem  <= sum_full[PROD_W-1:VALUE_BITS];
        dq   <= sum_full[VALUE_BITS-1:0];
        step <= '0;
      end
      vrms_pkg::B_DIV: begin
        rem  <= ge ? diff[CW-1:0] : trial[CW-1:0];
        dq   <= {dq[VALUE_BITS-2:0], ge};
        step <= step + CNT_W'(1);
      end
      vrms_pkg::B_WRITE: begin
        res_mean  <= dq;
        res_total <= n_r;
        res_occ   <= 1'b1;
      end
      default: begin
        res_occ <= res_occ;
      end
    endcase
  end

  // Output register: holds a finished word while the receiver stalls.
  assign mean_wide = CMP_W'(res_mean);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_value   <= mean_wide[vrms_pkg::SAMPLE_W-1:0];
      is_inside    <= res_occ && (mean_wide > CMP_W'(iso_level));
      sample_total <= res_total;
      status       <= res_status;
    end
  end

endmodule

@@ sv/voxel_running_mean_store.sv @@
// Voxel grid that keeps a running mean intensity and a sample count per voxel.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the operation
// (add, read, inside query, freeze) and s_tdata the voxel coordinates and a
// Q8.8 sample. Every input word yields exactly one output word on
// m_tvalid/m_tready with the mean, the inside flag, the count and a status.
// Configuration (grid sizes, iso level) is written through cfg_we, cfg_index
// and cfg_data while the block is idle.
// After reset the occupancy store is swept clear, one voxel per cycle, and
// s_tready stays low during the sweep. The front end forms and range-checks
// the voxel index in its multiply states and checks the sum when it offers
// the word to the queue. The back end fetches the voxel for a read, a query or
// an add; an add to an occupied voxel then goes through a multiply, the serial
// divider that produces one quotient bit per cycle, and a write before the
// word is done, while a fault or a freeze goes straight to the output.
// A two-word queue sits between the two ends, and an output register holds
// the finished word while m_tready is low; the front end takes a new word only
// after it has pushed the last one into the queue, so s_tready is low while it
// works on a word or waits for room in the queue.
module voxel_running_mean_store #(
  parameter int MAX_VOXELS = 65536,
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // voxel_x, voxel_y, voxel_z, sample_value
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // mean_value, is_inside, sample_total, zero fill
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_VOXELS);
  localparam int JOB_W = vrms_pkg::KIND_W + IDX_W + VALUE_BITS;

  // Configuration registers.
  logic [vrms_pkg::SIZE_W-1:0] size_x;
  logic [vrms_pkg::SIZE_W-1:0] size_y;
  logic [vrms_pkg::SIZE_W-1:0] size_z;
  logic [vrms_pkg::ISO_W-1:0]  iso_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x    <= vrms_pkg::SIZE_W'(64);
      size_y    <= vrms_pkg::SIZE_W'(64);
      size_z    <= vrms_pkg::SIZE_W'(16);
      iso_level <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vrms_pkg::REG_SIZE_X:    size_x    <= cfg_data[vrms_pkg::SIZE_W-1:0];
        vrms_pkg::REG_SIZE_Y:    size_y    <= cfg_data[vrms_pkg::SIZE_W-1:0];
        vrms_pkg::REG_SIZE_Z:    size_z    <= cfg_data[vrms_pkg::SIZE_W-1:0];
        vrms_pkg::REG_ISO_LEVEL: iso_level <= cfg_data;
        default: begin
          iso_level <= iso_level;
        end
      endcase
    end
  end

  // Front end to queue.
  logic                  f_valid;
  logic                  f_ready;
  vrms_pkg::job_kind_t   f_kind;
  logic [IDX_W-1:0]      f_idx;
  logic [VALUE_BITS-1:0] f_sample;
  logic                  clearing;

  // Queue to back end.
  logic                  q_valid;
  logic                  q_ready;
  logic [JOB_W-1:0]      q_data;

  logic [vrms_pkg::SAMPLE_W-1:0] mean_value;
  logic                          is_inside;
  logic [vrms_pkg::COUNT_W-1:0]  sample_total;

  vrms_front #(
    .MAX_VOXELS (MAX_VOXELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (s_tuser),
    .in_x       (s_tdata[7:0]),
    .in_y       (s_tdata[15:8]),
    .in_z       (s_tdata[23:16]),
    .in_sample  (s_tdata[39:24]),
    .size_x     (size_x),
    .size_y     (size_y),
    .size_z     (size_z),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job_kind   (f_kind),
    .job_idx    (f_idx),
    .job_sample (f_sample)
  );

  vrms_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_kind, f_idx, f_sample}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  vrms_back #(
    .MAX_VOXELS (MAX_VOXELS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .iso_level    (iso_level),
    .job_valid    (q_valid),
    .job_ready    (q_ready),
    .job_kind     (vrms_pkg::job_kind_t'(q_data[JOB_W-1 -: vrms_pkg::KIND_W])),
    .job_idx      (q_data[VALUE_BITS +: IDX_W]),
    .job_sample   (q_data[VALUE_BITS-1:0]),
    .clearing     (clearing),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .mean_value   (mean_value),
    .is_inside    (is_inside),
    .sample_total (sample_total),
    .status       (m_tuser)
  );

  assign m_tdata = {7'd0, sample_total, is_inside, mean_value};

endmodule

@@ dv/tb_voxel_running_mean_store.sv @@
module tb_voxel_running_mean_store;
  timeunit 1ns;
  timeprecision 1ps;

  // The grid depth and sample width match the defaults of the block.
  localparam int GRID_DEPTH = 65536;
  localparam int VALUE_BITS = 16;
  localparam longint unsigned COUNT_MAX = 65535;

  // Number of random words per grid setting, and the cycle limit. The limit
  // covers the occupancy sweep after reset (one voxel per cycle) and then
  // allows each word many times the slowest add plus the longest stalls.
  localparam int ITEMS_PER_GRID = 185;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 40;

  // One input word: the operation and its voxel and sample.
  typedef struct packed {
    logic [vrms_pkg::MODE_W-1:0]   mode;
    logic [vrms_pkg::COORD_W-1:0]  x;
    logic [vrms_pkg::COORD_W-1:0]  y;
    logic [vrms_pkg::COORD_W-1:0]  z;
    logic [vrms_pkg::SAMPLE_W-1:0] sample;
  } voxel_word_t;

  // One output word as the block should report it.
  typedef struct packed {
    logic [vrms_pkg::SAMPLE_W-1:0] mean;
    logic                          above_iso;
    logic [vrms_pkg::COUNT_W-1:0]  total;
    logic [vrms_pkg::STATUS_W-1:0] status;
  } voxel_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // voxel_x, voxel_y, voxel_z, sample_value
  logic [1:0]  s_tuser = '0;   // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // mean_value, is_inside, sample_total, zero fill
  logic [1:0]  m_tuser;        // status
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  voxel_running_mean_store #(
    .MAX_VOXELS(GRID_DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Words waiting to be sent, and replies the block still owes, oldest first.
  voxel_word_t  queued_words[$];
  voxel_reply_t owed_replies[$];

  // The testbench's own copy of the grid. Mean and count entries are only
  // ever looked at where the occupied bit is set.
  bit              voxel_used  [GRID_DEPTH];
  logic [15:0]     voxel_mean  [GRID_DEPTH];
  logic [15:0]     voxel_count [GRID_DEPTH];
  bit              adds_frozen = 1'b0;
  longint unsigned grid_x = 64;
  longint unsigned grid_y = 64;
  longint unsigned grid_z = 16;
  logic [15:0]     iso_level = '0;

  // Idle percentages of the sender and the receiver for the current stretch.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;

  // Coordinates of a recently used voxel, so that random adds pile up on the
  // same voxels and the running mean gets exercised beyond the first sample.
  logic [vrms_pkg::COORD_W-1:0] hot_x = '0;
  logic [vrms_pkg::COORD_W-1:0] hot_y = '0;
  logic [vrms_pkg::COORD_W-1:0] hot_z = '0;

  int cycle_count = 0;
  int fail_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int merged_adds = 0;
  int range_faults = 0;
  int rejected_adds = 0;
  int grid_settings = 0;
  bit in_taken = 1'b0;

  // Apply one word to the grid copy and return the reply it must produce.
  // Freeze is handled first, then the rejection of adds after a freeze, and
  // only then the range check, so a rejected add never reports a range fault.
  function automatic voxel_reply_t fold_into_grid(voxel_word_t w);
    voxel_reply_t    r;
    longint unsigned lin;
    logic [15:0]     vidx;
    longint unsigned n;
    longint unsigned acc;
    r = '0;
    r.status = vrms_pkg::ST_OK;
    if (w.mode == vrms_pkg::MODE_FREEZE) begin
      adds_frozen = 1'b1;
      return r;
    end
    if (w.mode == vrms_pkg::MODE_ADD && adds_frozen) begin
      r.status = vrms_pkg::ST_REJECT;
      rejected_adds++;
      return r;
    end
    if (64'(w.x) >= grid_x || 64'(w.y) >= grid_y || 64'(w.z) >= grid_z) begin
      r.status = vrms_pkg::ST_RANGE;
      range_faults++;
      return r;
    end
    lin = 64'(w.x) + 64'(w.y) * grid_x + 64'(w.z) * grid_x * grid_y;
    if (lin >= 64'(GRID_DEPTH)) begin
      r.status = vrms_pkg::ST_RANGE;
      range_faults++;
      return r;
    end
    vidx = 16'(lin);
    if (w.mode == vrms_pkg::MODE_ADD) begin
      if (!voxel_used[vidx]) begin
        voxel_used[vidx] = 1'b1;
        voxel_mean[vidx] = w.sample;
        voxel_count[vidx] = 16'd1;
      end else begin
        // The count holds at its maximum, but the mean keeps moving.
        n = 64'(voxel_count[vidx]) + 64'd1;
        if (n > COUNT_MAX) n = COUNT_MAX;
        acc = 64'(voxel_mean[vidx]) * (n - 64'd1) + 64'(w.sample);
        voxel_mean[vidx] = 16'(acc / n);
        voxel_count[vidx] = 16'(n);
        merged_adds++;
      end
    end
    if (voxel_used[vidx]) begin
      r.mean = voxel_mean[vidx];
      r.above_iso = (voxel_mean[vidx] > iso_level);
      r.total = voxel_count[vidx];
    end
    return r;
  endfunction

  function automatic voxel_word_t make_word(logic [vrms_pkg::MODE_W-1:0] mode,
                                            int unsigned x, int unsigned y,
                                            int unsigned z, int unsigned sample);
    voxel_word_t w;
    w.mode = mode;
    w.x = vrms_pkg::COORD_W'(x);
    w.y = vrms_pkg::COORD_W'(y);
    w.z = vrms_pkg::COORD_W'(z);
    w.sample = vrms_pkg::SAMPLE_W'(sample);
    return w;
  endfunction

  // A coordinate inside the given extent where there is one, else anywhere.
  function automatic logic [vrms_pkg::COORD_W-1:0] pick_coord(longint unsigned extent);
    if (extent == 0) return vrms_pkg::COORD_W'($urandom_range(255));
    if (extent > 256) return vrms_pkg::COORD_W'($urandom_range(255));
    return vrms_pkg::COORD_W'($urandom_range(32'(extent - 1), 0));
  endfunction

  // Random word: mostly adds and queries on valid voxels, often on a voxel
  // used just before, with some coordinates drawn over the whole field.
  function automatic voxel_word_t random_word(bit with_freeze);
    voxel_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) w.mode = vrms_pkg::MODE_ADD;
    else if (pick < 72) w.mode = vrms_pkg::MODE_READ;
    else if (pick < 96 || !with_freeze) w.mode = vrms_pkg::MODE_INSIDE;
    else w.mode = vrms_pkg::MODE_FREEZE;
    pick = $urandom_range(99);
    if (pick < 30) begin
      w.x = hot_x;
      w.y = hot_y;
      w.z = hot_z;
    end else if (pick < 85) begin
      w.x = pick_coord(grid_x);
      w.y = pick_coord(grid_y);
      w.z = pick_coord(grid_z);
    end else begin
      w.x = vrms_pkg::COORD_W'($urandom_range(255));
      w.y = vrms_pkg::COORD_W'($urandom_range(255));
      w.z = vrms_pkg::COORD_W'($urandom_range(255));
    end
    hot_x = w.x;
    hot_y = w.y;
    hot_z = w.z;
    pick = $urandom_range(99);
    if (pick < 8) w.sample = '0;
    else if (pick < 16) w.sample = '1;
    else w.sample = vrms_pkg::SAMPLE_W'($urandom_range(65535));
    return w;
  endfunction

  // Register writes happen at the falling edge, while the block is idle, and
  // the grid copy takes the same value so later predictions use it.
  task automatic write_reg(logic [vrms_pkg::REG_W-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      vrms_pkg::REG_SIZE_X:    grid_x = 64'(value[vrms_pkg::SIZE_W-1:0]);
      vrms_pkg::REG_SIZE_Y:    grid_y = 64'(value[vrms_pkg::SIZE_W-1:0]);
      vrms_pkg::REG_SIZE_Z:    grid_z = 64'(value[vrms_pkg::SIZE_W-1:0]);
      vrms_pkg::REG_ISO_LEVEL: iso_level = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(int unsigned sx, int unsigned sy, int unsigned sz,
                          int unsigned iso);
    write_reg(vrms_pkg::REG_SIZE_X, 16'(sx));
    write_reg(vrms_pkg::REG_SIZE_Y, 16'(sy));
    write_reg(vrms_pkg::REG_SIZE_Z, 16'(sz));
    write_reg(vrms_pkg::REG_ISO_LEVEL, 16'(iso));
    grid_settings++;
  endtask

  // Wait until every queued word went in and every reply came back.
  task automatic drain();
    while (queued_words.size() != 0 || owed_replies.size() != 0) @(posedge clk);
  endtask

  // Driver: inputs change only at the falling edge. A word that is offered
  // stays on the bus until the rising edge that takes it; a new word may be
  // offered, or withheld for an idle cycle, only after that.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!(s_tvalid && !in_taken)) begin
        if (queued_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= {queued_words[0].sample, queued_words[0].z,
                      queued_words[0].y, queued_words[0].x};
          s_tuser <= queued_words[0].mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Monitor: at each rising edge an accepted input word is folded into the
  // grid copy, and an accepted output word is checked against the oldest
  // reply still owed. The cycle counter ends a run that hangs.
  always @(posedge clk) begin : monitor
    voxel_word_t  taken;
    voxel_reply_t want;
    cycle_count = cycle_count + 1;
    in_taken <= (!rst && s_tvalid && s_tready);
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        taken = queued_words.pop_front();
        owed_replies.push_back(fold_into_grid(taken));
        words_sent++;
      end
      if (m_tvalid && m_tready) begin
        if (owed_replies.size() == 0) begin
          $error("output word with no reply owed: tdata %h tuser %h", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          words_checked++;
          if (m_tdata[15:0] !== want.mean) begin
            $error("mean_value: expected %0d, got %0d", want.mean, m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[16] !== want.above_iso) begin
            $error("is_inside: expected %0d, got %0d", want.above_iso, m_tdata[16]);
            fail_count++;
          end
          if (m_tdata[32:17] !== want.total) begin
            $error("sample_total: expected %0d, got %0d", want.total, m_tdata[32:17]);
            fail_count++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            fail_count++;
          end
          if (m_tdata[39:33] !== '0) begin
            $error("zero fill: expected 0, got %h", m_tdata[39:33]);
            fail_count++;
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d replies owed.", owed_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus. The store can only be frozen once, so freezing waits until the
  // last stretch; everything before it works on a live grid.
  initial begin : stimulus
    int unsigned k;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset sizes (64 x 64 x 16, iso level zero). The
    // block sweeps its occupancy store first, so the first word waits.
    sender_idle_pct = 31;
    receiver_idle_pct = 49;
    queued_words.push_back(make_word(vrms_pkg::MODE_READ, 0, 0, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_INSIDE, 0, 0, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 0, 0, 0, 16'h0000));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 0, 0, 0, 16'hFFFF));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 0, 0, 0, 16'hFFFF));
    queued_words.push_back(make_word(vrms_pkg::MODE_READ, 0, 0, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_INSIDE, 0, 0, 0, 0));
    // The last voxel of the default grid sits at the top of the index range.
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 63, 63, 15, 16'hFFFF));
    queued_words.push_back(make_word(vrms_pkg::MODE_READ, 63, 63, 15, 0));
    // Each coordinate just past its size, then all of them at the maximum.
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 64, 0, 0, 16'h1111));
    queued_words.push_back(make_word(vrms_pkg::MODE_READ, 0, 64, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_INSIDE, 0, 0, 16, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 255, 255, 255, 16'h1234));
    drain();

    // A full 256 x 256 plane: the largest coordinates are in range, and the
    // iso level sits right at a sample so that equal does not count as inside.
    set_grid(256, 256, 1, 16'h8000);
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 255, 255, 0, 16'h8000));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 255, 255, 0, 16'h8002));
    queued_words.push_back(make_word(vrms_pkg::MODE_INSIDE, 255, 255, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_READ, 0, 0, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 0, 0, 1, 16'h00FF));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 128, 1, 0, 16'h00FF));
    drain();

    // Random stretches: three idle patterns, three grid settings each. The
    // settings include a single voxel, a zero size, a 9-bit size and grids
    // whose linear index runs past the end of the store.
    for (int pace = 0; pace < 3; pace++) begin
      case (pace)
        0: begin
          sender_idle_pct = 31;
          receiver_idle_pct = 49;
        end
        1: begin
          sender_idle_pct = 49;
          receiver_idle_pct = 31;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int j = 0; j < 3; j++) begin
        k = 3 * pace + j;
        case (k)
          0: set_grid(256, 256, 1, 16'h8000);
          1: set_grid(4, 3, 2, $urandom_range(65535));
          2: set_grid(256, 256, 256, 16'hFFFF);
          3: set_grid(1, 1, 1, 16'h0000);
          4: set_grid(0, 5, 5, $urandom_range(65535));
          5: set_grid(511, 128, 2, $urandom_range(65535));
          6: set_grid(16, 16, 16, $urandom_range(65535));
          7: set_grid($urandom_range(256, 1), $urandom_range(256, 1),
                      $urandom_range(256, 1), $urandom_range(65535));
          default: set_grid(7, 9, 511, $urandom_range(65535));
        endcase
        for (int i = 0; i < ITEMS_PER_GRID; i++) queued_words.push_back(random_word(1'b0));
        drain();
      end
    end

    // Last stretch: a live start, then the freeze with out-of-range
    // coordinates, adds that must be rejected even where the voxel is out of
    // range, a read that still reports the kept count, an out-of-range query, a
    // second freeze, and random traffic on the frozen grid.
    sender_idle_pct = 31;
    receiver_idle_pct = 49;
    set_grid(8, 8, 8, 16'h4000);
    for (int i = 0; i < 20; i++) queued_words.push_back(random_word(1'b0));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 1, 1, 1, 16'h5000));
    queued_words.push_back(make_word(vrms_pkg::MODE_FREEZE, 200, 7, 255, 16'hABCD));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 1, 1, 1, 16'h0100));
    queued_words.push_back(make_word(vrms_pkg::MODE_ADD, 255, 0, 0, 16'h0100));
    queued_words.push_back(make_word(vrms_pkg::MODE_READ, 1, 1, 1, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_INSIDE, 9, 0, 0, 0));
    queued_words.push_back(make_word(vrms_pkg::MODE_FREEZE, 0, 0, 0, 0));
    for (int i = 0; i < 20; i++) queued_words.push_back(random_word(1'b1));
    drain();

    // Give the block time to show any stray word before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d replies never arrived", owed_replies.size());
      fail_count++;
    end

    $display("Checked %0d of %0d words over %0d grid settings.", words_checked, words_sent,
             grid_settings);
    $display("Saw %0d adds to occupied voxels, %0d range faults, %0d adds after freeze.",
             merged_adds, range_faults, rejected_adds);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
